### src/xmad_pkg.sv
// shared types, constants and helpers for the x86 mov access decoder
// no dependencies
package xmad_pkg;

	localparam int MAX_CODE_BYTES = 15;
	localparam int MAX_PREFIXES   = 4;
	localparam int NUM_REGS       = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam int CNT_W   = $clog2(MAX_CODE_BYTES + 1);
	localparam int REG_W   = $clog2(NUM_REGS);
	localparam int POS_W   = 5;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] OP_ESC      = 8'h0f;
	localparam logic [7:0] OP_ESC_38   = 8'h38;
	localparam logic [7:0] OP_ESC_3A   = 8'h3a;
	localparam logic [7:0] OP_ST_R8    = 8'h88;
	localparam logic [7:0] OP_ST_R     = 8'h89;
	localparam logic [7:0] OP_LD_R8    = 8'h8a;
	localparam logic [7:0] OP_LD_R     = 8'h8b;
	localparam logic [7:0] OP_LD_AL    = 8'ha0;
	localparam logic [7:0] OP_LD_AX    = 8'ha1;
	localparam logic [7:0] OP_ST_AL    = 8'ha2;
	localparam logic [7:0] OP_ST_AX    = 8'ha3;
	localparam logic [7:0] OP_ST_IMM8  = 8'hc6;
	localparam logic [7:0] OP_ST_IMM   = 8'hc7;
	localparam logic [7:0] PFX_OPSZ    = 8'h66;
	localparam logic [7:0] PFX_ADSZ    = 8'h67;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_TOO_LONG  = 3'd1,
		ERR_PREFIX    = 3'd2,
		ERR_OVERRUN   = 3'd3,
		ERR_REG_REG   = 3'd4,
		ERR_HIGH_BYTE = 3'd5,
		ERR_OPCODE    = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PARSE,
		ST_EXEC
	} state_t;

	typedef logic [MAX_CODE_BYTES-1:0][7:0] code_buf_t;

	typedef struct packed {
		code_buf_t  code;
		logic [1:0] mode_bits;
		logic       overflow;
		logic       store;
	} job_t;

	typedef struct packed {
		err_t       err;
		logic       is64;
		logic       rex;
		logic [3:0] opsz;
		logic [3:0] adsz;
		logic       escaped;
		logic [7:0] opc;
		logic [1:0] md;
		logic [3:0] rg;
		logic [2:0] rm;
		logic [POS_W-1:0] pos;
	} parse_t;

	function automatic logic [7:0] buf_at(code_buf_t b, logic [POS_W-1:0] i);
		logic [7:0] r;
		r = '0;
		if (int'(i) < MAX_CODE_BYTES)
			r = b[i[$clog2(MAX_CODE_BYTES)-1:0]];
		return r;
	endfunction

	function automatic logic is_legacy(logic [7:0] b);
		return (b == 8'hf0) || (b == 8'hf2) || (b == 8'hf3) || (b == 8'h2e) ||
			(b == 8'h36) || (b == 8'h3e) || (b == 8'h26) || (b == 8'h64) ||
			(b == 8'h65);
	endfunction

endpackage

### src/xmad_chan_if.sv
// valid/ready channel interfaces for decoder requests and results
// no dependencies
interface xmad_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        direction;
	logic [7:0]  code_byte;
	logic        first_byte;
	logic        last_byte;
	logic        cs_default_bit;
	logic        cs_long_bit;
	logic [3:0]  reg_index;
	logic [63:0] reg_value;
	modport source(output valid, mode, direction, code_byte, first_byte, last_byte,
		cs_default_bit, cs_long_bit, reg_index, reg_value, input ready);
	modport sink(input valid, mode, direction, code_byte, first_byte, last_byte,
		cs_default_bit, cs_long_bit, reg_index, reg_value, output ready);
endinterface

interface xmad_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  error_code;
	logic [3:0]  reg_id;
	logic [3:0]  access_size;
	logic [63:0] store_value;
	modport source(output valid, ok, error_code, reg_id, access_size, store_value,
		input ready);
	modport sink(input valid, ok, error_code, reg_id, access_size, store_value,
		output ready);
endinterface

### src/xmad_front.sv
// front end: code buffer, mode bits, register file, job hand-off on last byte
// depends on xmad_pkg, xmad_chan_if
module xmad_front (
	input  logic                         clk,
	input  logic                         arst_n,
	xmad_req_if.sink                     req,
	input  logic                         pending,
	input  logic                         q_full,
	output logic                         push,
	output xmad_pkg::job_t               push_job,
	input  logic [xmad_pkg::REG_W-1:0]   rd_idx,
	output logic [63:0]                  rd_data
);
	xmad_pkg::code_buf_t          code_q, code_n;
	logic [xmad_pkg::CNT_W-1:0]   cnt_q, cnt_n;
	logic                         ovf_q, ovf_n;
	logic [1:0]                   mb_q, mb_n;
	logic [63:0]                  rf_q [xmad_pkg::NUM_REGS];
	logic                         acc;

	// register loads wait until queued and in-flight decodes have read the file
	assign req.ready = req.mode ? !pending : !(req.last_byte && q_full);
	assign acc = req.valid && req.ready;
	assign rd_data = rf_q[rd_idx];

	always_comb begin
		code_n = code_q;
		cnt_n  = cnt_q;
		ovf_n  = ovf_q;
		mb_n   = mb_q;
		if (req.first_byte) begin
			code_n = '0;
			cnt_n  = '0;
			ovf_n  = 1'b0;
			mb_n   = {req.cs_long_bit, req.cs_default_bit};
		end
		if (int'(cnt_n) < xmad_pkg::MAX_CODE_BYTES) begin
			code_n[cnt_n[$clog2(xmad_pkg::MAX_CODE_BYTES)-1:0]] = req.code_byte;
			cnt_n = cnt_n + 1'b1;
		end else begin
			ovf_n = 1'b1;
		end
	end

	assign push = acc && !req.mode && req.last_byte;
	assign push_job = '{code: code_n, mode_bits: mb_n, overflow: ovf_n,
		store: req.direction};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			mb_q   <= '0;
			for (int i = 0; i < xmad_pkg::NUM_REGS; i++)
				rf_q[i] <= '0;
		end else if (acc) begin
			if (req.mode) begin
				rf_q[req.reg_index] <= req.reg_value;
			end else begin
				code_q <= code_n;
				cnt_q  <= cnt_n;
				ovf_q  <= ovf_n;
				mb_q   <= mb_n;
			end
		end
	end
endmodule

### src/xmad_queue.sv
// short job queue between front and back end
// depends on xmad_pkg
module xmad_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  xmad_pkg::job_t  push_job,
	input  logic            pop,
	output xmad_pkg::job_t  head,
	output logic            empty,
	output logic            full
);
	xmad_pkg::job_t                 mem_q [xmad_pkg::QUEUE_DEPTH];
	logic [xmad_pkg::QPTR_W-1:0]    wp_q, rp_q;
	logic [xmad_pkg::QCNT_W-1:0]    cnt_q;

	assign empty = cnt_q == '0;
	assign full  = int'(cnt_q) == xmad_pkg::QUEUE_DEPTH;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (int'(wp_q) == xmad_pkg::QUEUE_DEPTH - 1) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (int'(rp_q) == xmad_pkg::QUEUE_DEPTH - 1) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

### src/xmad_back.sv
// back end: prefix/opcode/modrm parse, operand fetch, result register
// depends on xmad_pkg, xmad_chan_if
module xmad_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  xmad_pkg::job_t               head,
	input  logic                         empty,
	output logic                         pop,
	output logic                         busy,
	output logic [xmad_pkg::REG_W-1:0]   rd_idx,
	input  logic [63:0]                  rd_data,
	xmad_rsp_if.source                   rsp
);
	xmad_pkg::state_t  state_q, state_n;
	xmad_pkg::job_t    job_q;
	xmad_pkg::parse_t  pr_q, pr_n;
	logic              load_out;
	logic              out_free;

	logic              o_valid_q;
	logic              o_ok_q;
	logic [2:0]        o_err_q;
	logic [3:0]        o_rid_q;
	logic [3:0]        o_size_q;
	logic [63:0]       o_val_q;

	xmad_pkg::err_t    ex_err;
	logic [3:0]        ex_rid;
	logic [3:0]        ex_size;
	logic [63:0]       ex_val;

	assign out_free = !o_valid_q || rsp.ready;
	assign busy = state_q != xmad_pkg::ST_IDLE;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			xmad_pkg::ST_IDLE:  if (!empty) state_n = xmad_pkg::ST_PARSE;
			xmad_pkg::ST_PARSE: state_n = xmad_pkg::ST_EXEC;
			xmad_pkg::ST_EXEC:  if (out_free) state_n = xmad_pkg::ST_IDLE;
			default:            state_n = xmad_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			xmad_pkg::ST_IDLE:  pop = !empty;
			xmad_pkg::ST_PARSE: ;
			xmad_pkg::ST_EXEC:  load_out = out_free;
			default: ;
		endcase
	end

	// prefixes, rex, escapes, opcode and modrm
	always_comb begin
		logic [xmad_pkg::POS_W-1:0] pos;
		logic               stop, p66, p67, rw;
		logic [7:0]         b;
		logic [3:0]         dflt;
		xmad_pkg::err_t     e;
		pos = '0; stop = 1'b0; p66 = 1'b0; p67 = 1'b0; rw = 1'b0;
		e = xmad_pkg::ERR_NONE;
		pr_n = '0;
		pr_n.is64 = job_q.mode_bits == 2'b10;
		dflt = (job_q.mode_bits == 2'b00) ? 4'd2 : 4'd4;
		for (int k = 0; k < xmad_pkg::MAX_PREFIXES; k++) begin
			if (!stop) begin
				b = xmad_pkg::buf_at(job_q.code, pos);
				if (b == xmad_pkg::PFX_OPSZ) begin
					p66 = 1'b1;
					pos = pos + 1'b1;
				end else if (b == xmad_pkg::PFX_ADSZ) begin
					p67 = 1'b1;
					pos = pos + 1'b1;
				end else if (xmad_pkg::is_legacy(b)) begin
					e = xmad_pkg::ERR_PREFIX;
					stop = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end
		end
		b = xmad_pkg::buf_at(job_q.code, pos);
		if (pr_n.is64 && b[7:4] == 4'h4) begin
			pr_n.rex = 1'b1;
			if (b[3]) begin
				rw = 1'b1;
				p66 = 1'b0;
				p67 = 1'b0;
			end
			pr_n.rg[3] = b[2];
			pos = pos + 1'b1;
		end
		pr_n.opsz = p66 ? 4'd6 - dflt : dflt + (rw ? 4'd4 : 4'd0);
		pr_n.adsz = p67 ? 4'd6 - dflt : dflt;
		if (xmad_pkg::buf_at(job_q.code, pos) == xmad_pkg::OP_ESC) begin
			pr_n.escaped = 1'b1;
			pos = pos + 1'b1;
		end
		b = xmad_pkg::buf_at(job_q.code, pos);
		if (b == xmad_pkg::OP_ESC_38 || b == xmad_pkg::OP_ESC_3A) begin
			pr_n.escaped = 1'b1;
			pos = pos + 1'b1;
		end
		pr_n.opc = xmad_pkg::buf_at(job_q.code, pos);
		pos = pos + 1'b1;
		b = xmad_pkg::buf_at(job_q.code, pos);
		pr_n.md = b[7:6];
		pr_n.rg[2:0] = b[5:3];
		pr_n.rm = b[2:0];
		pr_n.pos = pos + 1'b1;
		pr_n.err = job_q.overflow ? xmad_pkg::ERR_TOO_LONG : e;
	end

	// operand read index: high-byte stores use the low register of the pair
	always_comb begin
		if (pr_q.opc == xmad_pkg::OP_ST_AX || pr_q.opc == xmad_pkg::OP_ST_AL)
			rd_idx = '0;
		else if (pr_q.opc == xmad_pkg::OP_ST_R8 && !pr_q.rex && pr_q.rg[3:2] == 2'b01)
			rd_idx = pr_q.rg - 4'd4;
		else
			rd_idx = pr_q.rg;
	end

	// execute
	always_comb begin
		logic [xmad_pkg::POS_W-1:0] p;
		logic               hi;
		logic [7:0]         sib;
		logic [31:0]        imm;
		ex_err = pr_q.err;
		ex_rid = '0;
		ex_size = '0;
		ex_val = '0;
		p = pr_q.pos;
		hi = !pr_q.rex && pr_q.rg[3:2] == 2'b01;
		sib = '0;
		imm = '0;
		if (pr_q.err == xmad_pkg::ERR_NONE) begin
			if (pr_q.escaped) begin
				ex_err = xmad_pkg::ERR_OPCODE;
			end else if (!job_q.store) begin
				unique case (pr_q.opc)
					xmad_pkg::OP_LD_R8: begin
						if (pr_q.md == 2'd3) ex_err = xmad_pkg::ERR_REG_REG;
						else if (hi) ex_err = xmad_pkg::ERR_HIGH_BYTE;
						ex_rid = pr_q.rg;
						ex_size = 4'd1;
					end
					xmad_pkg::OP_LD_R: begin
						if (pr_q.md == 2'd3) ex_err = xmad_pkg::ERR_REG_REG;
						ex_rid = pr_q.rg;
						ex_size = pr_q.opsz;
					end
					xmad_pkg::OP_LD_AX: ex_size = pr_q.opsz;
					xmad_pkg::OP_LD_AL: ex_size = 4'd1;
					default: ex_err = xmad_pkg::ERR_OPCODE;
				endcase
			end else begin
				unique case (pr_q.opc)
					xmad_pkg::OP_ST_R8: begin
						if (pr_q.md == 2'd3) ex_err = xmad_pkg::ERR_REG_REG;
						else if (hi && pr_q.is64) ex_err = xmad_pkg::ERR_HIGH_BYTE;
						ex_val = {56'd0, hi ? rd_data[15:8] : rd_data[7:0]};
						ex_size = 4'd1;
					end
					xmad_pkg::OP_ST_R: begin
						if (pr_q.md == 2'd3) ex_err = xmad_pkg::ERR_REG_REG;
						ex_val = rd_data;
						ex_size = pr_q.opsz;
					end
					xmad_pkg::OP_ST_AX: begin
						ex_val = rd_data;
						ex_size = pr_q.opsz;
					end
					xmad_pkg::OP_ST_AL: begin
						ex_val = rd_data;
						ex_size = 4'd1;
					end
					xmad_pkg::OP_ST_IMM8, xmad_pkg::OP_ST_IMM: begin
						if (pr_q.rm == 3'd4 && pr_q.adsz == 4'd4) begin
							sib = xmad_pkg::buf_at(job_q.code, p);
							if (pr_q.md == 2'd0 && sib[2:0] == 3'd5)
								p = p + 5'd4;
							p = p + 5'd1;
						end
						if (pr_q.md == 2'd1)
							p = p + 5'd1;
						else if (pr_q.md == 2'd2 ||
							(pr_q.md == 2'd0 && pr_q.rm == 3'd6 && pr_q.adsz == 4'd2) ||
							(pr_q.md == 2'd0 && pr_q.rm == 3'd5 && pr_q.adsz == 4'd4))
							p = p + 5'(pr_q.adsz);
						for (int k = 0; k < 4; k++)
							imm[8*k +: 8] = xmad_pkg::buf_at(job_q.code, p + 5'(k));
						if (pr_q.md == 2'd3) ex_err = xmad_pkg::ERR_REG_REG;
						else if (int'(p) > xmad_pkg::MAX_CODE_BYTES)
							ex_err = xmad_pkg::ERR_OVERRUN;
						if (pr_q.opc == xmad_pkg::OP_ST_IMM8) begin
							ex_val = {56'd0, imm[7:0]};
							ex_size = 4'd1;
						end else begin
							// sign extend from 16 or 32 bits, chosen by the address size
							if (pr_q.adsz == 4'd2)
								ex_val = {{48{imm[15]}}, imm[15:0]};
							else
								ex_val = {{32{imm[31]}}, imm};
							ex_size = pr_q.opsz;
						end
					end
					default: ex_err = xmad_pkg::ERR_OPCODE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (state_q == xmad_pkg::ST_PARSE)
			pr_q <= pr_n;
		if (load_out) begin
			o_ok_q   <= ex_err == xmad_pkg::ERR_NONE;
			o_err_q  <= ex_err;
			o_rid_q  <= (ex_err == xmad_pkg::ERR_NONE && !job_q.store) ? ex_rid : 4'd0;
			o_size_q <= (ex_err == xmad_pkg::ERR_NONE) ? ex_size : 4'd0;
			o_val_q  <= (ex_err == xmad_pkg::ERR_NONE && job_q.store) ? ex_val : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= xmad_pkg::ST_IDLE;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out)
				o_valid_q <= 1'b1;
			else if (rsp.ready)
				o_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = o_valid_q;
	assign rsp.ok          = o_ok_q;
	assign rsp.error_code  = o_err_q;
	assign rsp.reg_id      = o_rid_q;
	assign rsp.access_size = o_size_q;
	assign rsp.store_value = o_val_q;
endmodule

### src/x86_mov_access_decoder.sv
// x86 mov access decoder top: front end, job queue, back end
// bytes and register loads are taken one word per cycle while ready is high; a last byte queues a decode
// the back end pops a decode in idle, parses it, executes it, then loads the result register
// result valid comes later behind queued decodes or while the result register is stalled
// two decodes may be queued; register loads stall while any decode is queued or in flight
// asynchronous reset clears buffer, counters, register file, queue and result valid
module x86_mov_access_decoder (
	input  logic        clk,
	input  logic        arst_n,
	xmad_req_if.sink    req,
	xmad_rsp_if.source  rsp
);
	logic                        push, pop, q_empty, q_full, busy;
	xmad_pkg::job_t              push_job, head;
	logic [xmad_pkg::REG_W-1:0]  rd_idx;
	logic [63:0]                 rd_data;

	xmad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.pending  (!q_empty || busy),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data)
	);

	xmad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	xmad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.busy     (busy),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.rsp      (rsp)
	);
endmodule
